/* hw/rtl/gaussian_3x3_field_smoother_top_defines.svh */
// Assertion macros for the 3x3 field smoother.
// Used by files that check their own logic; expects clk and arst_n in scope.
`ifndef GAUSSIAN_3X3_FIELD_SMOOTHER_TOP_DEFINES_SVH
`define GAUSSIAN_3X3_FIELD_SMOOTHER_TOP_DEFINES_SVH

// same-cycle implication
`define GFS_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/gfs_pkg.sv */
// Shared types, constants and helpers for the 3x3 field smoother.
// No dependencies.
package gfs_pkg;

	localparam int MAX_WIDTH      = 1024;
	localparam int MAX_HEIGHT     = 1024;
	localparam int SAMPLE_BITS    = 16;
	localparam int DIM_BITS       = 11;
	localparam int COL_BITS       = $clog2(MAX_WIDTH);
	localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
	localparam int IN_ROW_BITS    = ROW_BITS + 1;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = DIM_BITS;
	localparam int LINE_BITS      = 2 * SAMPLE_BITS;

	localparam int COLSUM_BITS    = SAMPLE_BITS + 2;
	localparam int SUM_BITS       = SAMPLE_BITS + 5;
	localparam int NUM_BITS       = SUM_BITS + 1;

	// kernel weight totals: interior, edge, corner
	localparam int WEIGHT_INTERIOR = 16;
	localparam int WEIGHT_EDGE     = 12;
	localparam int WEIGHT_CORNER   = 9;

	// floor(n/3) = (n*RECIP3) >> RECIP3_SHIFT for n < 2^19
	// floor(n/9) = (n*RECIP9) >> RECIP9_SHIFT for n < 2^20
	localparam int QN_BITS       = SAMPLE_BITS + 4;
	localparam int RECIP_BITS    = 21;
	localparam int PROD_BITS     = QN_BITS + RECIP_BITS;
	localparam int RECIP3        = 699051;
	localparam int RECIP3_SHIFT  = 21;
	localparam int RECIP9        = 1864136;
	localparam int RECIP9_SHIFT  = 24;
	localparam int DIV16_SHIFT   = 5;
	localparam int DIV12_PRE     = 3;
	localparam int DIV9_PRE      = 1;

	localparam int FIFO_DEPTH    = 8;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

	localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_PUSH  = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		DIV_16 = 2'd0,
		DIV_12 = 2'd1,
		DIV_9  = 2'd2
	} div_t;

	typedef struct packed {
		logic emit;
		logic pre;
		logic shift;
		logic top;
		logic bot;
		logic left;
		logic right;
		logic last;
	} s1_ctl_t;

	function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
		input logic [DIM_BITS-1:0] hi);
		logic [DIM_BITS-1:0] r;
		if (v < DIM_BITS'(2)) begin
			r = DIM_BITS'(2);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/gfs_if.sv */
// Request channels of the 3x3 field smoother: sample stream in, result stream out.
// Depends on gfs_pkg.
interface gfs_in_if;
	import gfs_pkg::*;
	logic    valid;
	logic    ready;
	logic    op;
	sample_t sample;
	modport source (output valid, op, sample, input ready);
	modport sink (input valid, op, sample, output ready);
endinterface

interface gfs_out_if;
	import gfs_pkg::*;
	logic    valid;
	logic    ready;
	sample_t smoothed;
	logic    last_of_frame;
	modport source (output valid, smoothed, last_of_frame, input ready);
	modport sink (input valid, smoothed, last_of_frame, output ready);
endinterface

/* hw/rtl/gfs_line_mem.sv */
// Line store: upper and middle rows packed in one word, one write and one read port.
// Registered read. Depends on gfs_pkg.
module gfs_line_mem (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [gfs_pkg::COL_BITS-1:0]   wr_addr,
	input  logic [gfs_pkg::LINE_BITS-1:0]  wr_data,
	input  logic                           rd_en,
	input  logic [gfs_pkg::COL_BITS-1:0]   rd_addr,
	output logic [gfs_pkg::LINE_BITS-1:0]  rd_data
);
	import gfs_pkg::*;

	logic [LINE_BITS-1:0] mem_q [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hw/rtl/gfs_window.sv */
// 3x3 window and weighted 1-2-1 sum with border masking.
// Samples kept offset-binary so the sum is unsigned. Depends on gfs_pkg.
module gfs_window (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gfs_pkg::s1_ctl_t               ctl_s1,
	input  logic [gfs_pkg::SAMPLE_BITS-1:0] val_s1,
	input  logic [gfs_pkg::LINE_BITS-1:0]  line_rd,
	output logic                           emit_s2,
	output logic                           last_s2,
	output gfs_pkg::div_t                  div_s2,
	output logic [gfs_pkg::SUM_BITS-1:0]   sum_s2
);
	import gfs_pkg::*;

	logic [SAMPLE_BITS-1:0] win_q [9];
	logic [SAMPLE_BITS-1:0] win_n [9];
	logic [SAMPLE_BITS-1:0] tap [3][3];
	logic [COLSUM_BITS-1:0] cs [3];
	logic [SUM_BITS-1:0]    sum;
	div_t                   div;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_n[r*3]   = ctl_s1.shift ? win_q[r*3+1] : win_q[r*3];
			win_n[r*3+1] = ctl_s1.shift ? win_q[r*3+2] : win_q[r*3+1];
		end
		win_n[2] = ctl_s1.shift ? line_rd[LINE_BITS-1:SAMPLE_BITS] : win_q[2];
		win_n[5] = ctl_s1.shift ? line_rd[SAMPLE_BITS-1:0] : win_q[5];
		win_n[8] = ctl_s1.shift ? val_s1 : win_q[8];

		// row-end result uses the window before the shift, centered one column right
		for (int r = 0; r < 3; r++) begin
			if (ctl_s1.pre) begin
				tap[r][0] = win_q[r*3+1];
				tap[r][1] = win_q[r*3+2];
				tap[r][2] = '0;
			end else begin
				tap[r][0] = win_n[r*3];
				tap[r][1] = win_n[r*3+1];
				tap[r][2] = win_n[r*3+2];
			end
		end

		for (int c = 0; c < 3; c++) begin
			cs[c] = (ctl_s1.top ? COLSUM_BITS'(tap[0][c]) : '0)
				+ COLSUM_BITS'({tap[1][c], 1'b0})
				+ (ctl_s1.bot ? COLSUM_BITS'(tap[2][c]) : '0);
		end
		sum = (ctl_s1.left ? SUM_BITS'(cs[0]) : '0)
			+ SUM_BITS'({cs[1], 1'b0})
			+ (ctl_s1.right ? SUM_BITS'(cs[2]) : '0);

		if ((ctl_s1.top && ctl_s1.bot) && (ctl_s1.left && ctl_s1.right)) begin
			div = DIV_16;
		end else if ((ctl_s1.top && ctl_s1.bot) || (ctl_s1.left && ctl_s1.right)) begin
			div = DIV_12;
		end else begin
			div = DIV_9;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.shift) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= win_n[i];
			end
		end
		sum_s2  <= sum;
		div_s2  <= div;
		last_s2 <= ctl_s1.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
		end else begin
			emit_s2 <= ctl_s1.emit;
		end
	end

endmodule

/* hw/rtl/gfs_divide.sv */
// Rounded division of the weighted sum by 16, 12 or 9 (half up).
// Constant-reciprocal multiply, result registered. Depends on gfs_pkg.
module gfs_divide (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            emit_s2,
	input  logic                            last_s2,
	input  gfs_pkg::div_t                   div_s2,
	input  logic [gfs_pkg::SUM_BITS-1:0]    sum_s2,
	output logic                            valid_s3,
	output logic                            last_s3,
	output logic [gfs_pkg::SAMPLE_BITS-1:0] smoothed_s3
);
	import gfs_pkg::*;

	logic [NUM_BITS-1:0]    y;
	logic [NUM_BITS-1:0]    weight;
	logic [QN_BITS-1:0]     n;
	logic [RECIP_BITS-1:0]  recip;
	logic [PROD_BITS-1:0]   prod;
	logic [SAMPLE_BITS-1:0] q;

	always_comb begin
		case (div_s2)
			DIV_16:  weight = NUM_BITS'(WEIGHT_INTERIOR);
			DIV_12:  weight = NUM_BITS'(WEIGHT_EDGE);
			DIV_9:   weight = NUM_BITS'(WEIGHT_CORNER);
			default: weight = NUM_BITS'(WEIGHT_CORNER);
		endcase
		// floor((2x + d) / 2d), x already offset to be non-negative
		y = {sum_s2, 1'b0} + weight;
		if (div_s2 == DIV_12) begin
			n     = QN_BITS'(y >> DIV12_PRE);
			recip = RECIP_BITS'(RECIP3);
		end else begin
			n     = QN_BITS'(y >> DIV9_PRE);
			recip = RECIP_BITS'(RECIP9);
		end
		prod = PROD_BITS'(n) * PROD_BITS'(recip);
		case (div_s2)
			DIV_16:  q = y[DIV16_SHIFT +: SAMPLE_BITS];
			DIV_12:  q = prod[RECIP3_SHIFT +: SAMPLE_BITS];
			DIV_9:   q = prod[RECIP9_SHIFT +: SAMPLE_BITS];
			default: q = prod[RECIP9_SHIFT +: SAMPLE_BITS];
		endcase
	end

	always_ff @(posedge clk) begin
		smoothed_s3 <= q ^ SIGN_FLIP;
		last_s3     <= last_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= emit_s2;
		end
	end

endmodule

/* hw/rtl/gfs_out_fifo.sv */
// Eight-entry result queue driving the output channel.
// Depends on gfs_pkg and gfs_out_if.
module gfs_out_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic                              push_last,
	input  logic [gfs_pkg::SAMPLE_BITS-1:0]   push_smoothed,
	gfs_out_if.source                         result,
	output logic [gfs_pkg::FIFO_CNT_BITS-1:0] cnt
);
	import gfs_pkg::*;

	logic [SAMPLE_BITS-1:0]   data_q [FIFO_DEPTH];
	logic                     last_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0] cnt_q;
	logic                     pop;

	assign pop                  = result.valid && result.ready;
	assign result.valid         = cnt_q != '0;
	assign result.smoothed      = sample_t'(data_q[rd_ptr_q]);
	assign result.last_of_frame = last_q[rd_ptr_q];
	assign cnt                  = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= push_smoothed;
			last_q[wr_ptr_q] <= push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + FIFO_CNT_BITS'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - FIFO_CNT_BITS'(1);
			end
		end
	end

endmodule

/* hw/rtl/gaussian_3x3_field_smoother_top.sv */
// Top level of the 3x3 1-2-1 field smoother: raster counters, line store access,
// window, divider and result queue. Depends on gfs_pkg, gfs_if and the gfs_* units.
//
//   channel  dir  request payload                    handshake
//   field    in   op, sample                         valid/ready
//   result   out  smoothed, last_of_frame            valid/ready
//   cfg      in   cfg_index, cfg_wdata               cfg_wr_en, no stall
//
// One request per cycle while field.ready is high. A result passes the s1, s2 and
// s3 registers after its releasing request, width+1 requests after its own sample.
// The line store is one 1024x32 RAM: read at accept, written back in the next cycle.
// No clearing pass: stale line entries fall outside the field and are masked.
// field.ready drops when the 8-entry result queue plus results in flight is full.
// Reset: width and height 1024, counters zero.
`include "gaussian_3x3_field_smoother_top_defines.svh"

module gaussian_3x3_field_smoother_top (
	input  logic                                clk,
	input  logic                                arst_n,
	gfs_in_if.sink                              field,
	gfs_out_if.source                           result,
	input  logic                                cfg_wr_en,
	input  logic [gfs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [gfs_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
	import gfs_pkg::*;

	logic [DIM_BITS-1:0]    width_q, height_q, w_use, h_use;
	logic [COL_BITS-1:0]    in_col_q, out_col_q;
	logic [IN_ROW_BITS-1:0] in_row_q;
	logic [ROW_BITS-1:0]    out_row_q;
	logic [DIM_BITS-1:0]    in_col_inc, out_col_inc, out_row_inc;

	logic accept, act, live, is_drain;
	logic pre_now, post_now, emit_now, shift_now, last_now;
	s1_ctl_t ctl_now, ctl_s1;

	logic [COL_BITS-1:0]    addr_s1;
	logic [SAMPLE_BITS-1:0] val_now, val_s1;

	logic                   line_rd_en;
	logic [LINE_BITS-1:0]   line_rd_data, line_wr_data;

	logic                   emit_s2, last_s2;
	div_t                   div_s2;
	logic [SUM_BITS-1:0]    sum_s2;

	logic                   res_push, res_last;
	logic [SAMPLE_BITS-1:0] res_smoothed;
	logic [FIFO_CNT_BITS-1:0] fifo_cnt;

	always_comb begin
		w_use       = clamp_dim(width_q, DIM_BITS'(MAX_WIDTH));
		h_use       = clamp_dim(height_q, DIM_BITS'(MAX_HEIGHT));
		in_col_inc  = DIM_BITS'(in_col_q) + DIM_BITS'(1);
		out_col_inc = DIM_BITS'(out_col_q) + DIM_BITS'(1);
		out_row_inc = DIM_BITS'(out_row_q) + DIM_BITS'(1);

		accept   = field.valid && field.ready;
		is_drain = field.op == OP_DRAIN;
		live     = in_row_q < h_use;
		act      = accept && !(is_drain && live);

		pre_now   = (in_col_q == '0) && (in_row_q >= IN_ROW_BITS'(2));
		post_now  = (in_col_q != '0) && (in_row_q != '0);
		emit_now  = pre_now || post_now;
		shift_now = in_row_q <= h_use;
		last_now  = emit_now && (out_row_inc == h_use) && (out_col_inc == w_use);

		val_now = (is_drain || !live) ? SIGN_FLIP : (field.sample ^ SIGN_FLIP);

		ctl_now.emit  = act && emit_now;
		ctl_now.pre   = pre_now;
		ctl_now.shift = act && shift_now;
		ctl_now.top   = out_row_q != '0;
		ctl_now.bot   = out_row_inc < h_use;
		ctl_now.left  = out_col_q != '0;
		ctl_now.right = out_col_inc < w_use;
		ctl_now.last  = last_now;

		line_rd_en   = act && shift_now;
		line_wr_data = {line_rd_data[SAMPLE_BITS-1:0], val_s1};

		field.ready = (fifo_cnt + FIFO_CNT_BITS'(ctl_s1.emit) + FIFO_CNT_BITS'(emit_s2)
			+ FIFO_CNT_BITS'(res_push)) < FIFO_CNT_BITS'(FIFO_DEPTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= DIM_BITS'(MAX_WIDTH);
			height_q  <= DIM_BITS'(MAX_HEIGHT);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			ctl_s1    <= '0;
		end else begin
			ctl_s1 <= ctl_now;
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_WIDTH:  width_q  <= cfg_wdata;
					REG_HEIGHT: height_q <= cfg_wdata;
					default: ;
				endcase
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else if (act) begin
				if (last_now) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else begin
					if (emit_now) begin
						if (out_col_inc >= w_use) begin
							out_col_q <= '0;
							out_row_q <= out_row_inc[ROW_BITS-1:0];
						end else begin
							out_col_q <= out_col_inc[COL_BITS-1:0];
						end
					end
					if (in_col_inc >= w_use) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + IN_ROW_BITS'(1);
					end else begin
						in_col_q <= in_col_inc[COL_BITS-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= in_col_q;
		val_s1  <= val_now;
	end

	gfs_line_mem u_line_mem (
		.clk     (clk),
		.wr_en   (ctl_s1.shift),
		.wr_addr (addr_s1),
		.wr_data (line_wr_data),
		.rd_en   (line_rd_en),
		.rd_addr (in_col_q),
		.rd_data (line_rd_data)
	);

	gfs_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s1  (ctl_s1),
		.val_s1  (val_s1),
		.line_rd (line_rd_data),
		.emit_s2 (emit_s2),
		.last_s2 (last_s2),
		.div_s2  (div_s2),
		.sum_s2  (sum_s2)
	);

	gfs_divide u_divide (
		.clk         (clk),
		.arst_n      (arst_n),
		.emit_s2     (emit_s2),
		.last_s2     (last_s2),
		.div_s2      (div_s2),
		.sum_s2      (sum_s2),
		.valid_s3    (res_push),
		.last_s3     (res_last),
		.smoothed_s3 (res_smoothed)
	);

	gfs_out_fifo u_out_fifo (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (res_push),
		.push_last     (res_last),
		.push_smoothed (res_smoothed),
		.result        (result),
		.cnt           (fifo_cnt)
	);

	`GFS_ASSERT(a_line_rw_apart, line_rd_en && ctl_s1.shift, in_col_q != addr_s1, "line store read and write hit the same column")
	`GFS_ASSERT(a_fifo_room, res_push && !(result.valid && result.ready), fifo_cnt < FIFO_CNT_BITS'(FIFO_DEPTH), "result queue overflow")
	`GFS_ASSERT_NEXT(a_final_clears, act && last_now && !cfg_wr_en, (in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0), "counters not cleared after final result")
	`GFS_ASSERT(a_pos_range, 1'b1, (DIM_BITS'(out_row_q) < h_use) && (DIM_BITS'(in_col_q) < w_use), "raster position outside the field")

endmodule
